// ----- hdl/i2c_transaction_bit_encoder_assert.svh -----
// assertion macros used by the encoder checker
`ifndef I2C_TRANSACTION_BIT_ENCODER_ASSERT_SVH
`define I2C_TRANSACTION_BIT_ENCODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define I2CBE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define I2CBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/i2cbe_pkg.sv -----
// shared types and constants of the i2c transaction bit encoder
package i2cbe_pkg;

    // bus bit codes
    localparam logic [1:0] CODE_ZERO  = 2'd0;
    localparam logic [1:0] CODE_ONE   = 2'd1;
    localparam logic [1:0] CODE_START = 2'd2;
    localparam logic [1:0] CODE_STOP  = 2'd3;

    // codes per byte: eight data bits plus the ack slot
    localparam int BYTE_CODES    = 9;
    // codes per (re)start: start code plus address byte
    localparam int ADDRESS_CODES = 10;
    // budget margins checked before a data byte and before a restart
    localparam int BYTE_MARGIN    = 10;
    localparam int RESTART_MARGIN = 11;

    localparam logic [7:0] READ_BYTE = 8'hFF;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ADDR,
        S_DATA,
        S_STOP,
        S_ABORT
    } t_seq_state;

    // position within the command
    typedef enum logic [1:0] {
        POS_ADDR,
        POS_FIRST,
        POS_MORE
    } t_item_pos;

    // control of the shared byte shifter
    typedef struct packed {
        logic       load;
        logic       shift;
        logic [7:0] value;
    } t_shift_ctl;

    // status of the shared byte shifter
    typedef struct packed {
        logic code_bit;
        logic done;
    } t_shift_sts;

endpackage

// ----- hdl/i2cbe_item_if.sv -----
// request channel carrying byte items into the encoder
interface i2cbe_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] byte_value;
    logic       last_item;

    modport source (output valid, output action, output byte_value, output last_item,
                    input ready);
    modport sink (input valid, input action, input byte_value, input last_item,
                  output ready);
endinterface

// ----- hdl/i2cbe_code_if.sv -----
// request channel carrying bit codes out of the encoder
interface i2cbe_code_if;
    logic       valid;
    logic       ready;
    logic [1:0] bit_code;
    logic       speed_flag;
    logic       end_of_command;
    logic       aborted;

    modport source (output valid, output bit_code, output speed_flag,
                    output end_of_command, output aborted, input ready);
    modport sink (input valid, input bit_code, input speed_flag,
                  input end_of_command, input aborted, output ready);
endinterface

// ----- hdl/i2cbe_byte_shifter.sv -----
// shared msb-first byte shifter with ack slot counter
module i2cbe_byte_shifter (
    input  logic                  i_clk,
    input  i2cbe_pkg::t_shift_ctl i_ctl,
    output i2cbe_pkg::t_shift_sts o_sts
);
    import i2cbe_pkg::*;

    localparam logic [3:0] LAST_SLOT = 4'(BYTE_CODES - 1);

    logic [7:0] r_shreg;
    logic [7:0] n_shreg;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;

    // load a new byte or shift out one bit
    always_comb begin
        n_shreg = r_shreg;
        n_cnt   = r_cnt;
        if (i_ctl.load) begin
            n_shreg = i_ctl.value;
            n_cnt   = 4'd0;
        end else if (i_ctl.shift) begin
            n_shreg = {r_shreg[6:0], 1'b0};
            n_cnt   = r_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shreg <= n_shreg;
        r_cnt   <= n_cnt;
    end

    // ack slot always drives a one
    assign o_sts.done     = (r_cnt == LAST_SLOT);
    assign o_sts.code_bit = o_sts.done ? 1'b1 : r_shreg[7];

endmodule

// ----- hdl/i2c_transaction_bit_encoder.sv -----
// top level of the i2c transaction bit encoder
//
//  channel   dir  handshake     payload
//  i_item    in   valid/ready   action, byte_value, last_item
//  o_code    out  valid/ready   bit_code, speed_flag, end_of_command, aborted
//  cfg       in   i_cfg_we      i_cfg_wdata (fast_clock)
//
// an item yields one code per cycle while o_code is not stalled: up to 20 codes
// for a first or restarting item (start, 9 address codes, 9 data codes, stop),
// 9 or 10 for a later one, 1 for an abort, 0 for a held or swallowed item.
// a restart whose data byte overruns the budget gives only its 10 start and
// address codes, and 11 with the abort when it is the last item.
// the byte shifter serves address and data bytes one bit a cycle while o_code is not stalled.
// i_item.ready is high only while the sequencer is idle.
// a stalled o_code holds the sequencer and its code in place.
// reset is synchronous and active low; it clears the sequencer and command state.
module i2c_transaction_bit_encoder #(
    parameter int MAX_PACKET_BITS = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    i2cbe_item_if.sink   i_item,
    i2cbe_code_if.source o_code
);
    import i2cbe_pkg::*;

    localparam int CNT_W = $clog2(MAX_PACKET_BITS);
    localparam logic [CNT_W:0] LIM_BYTE    = (CNT_W + 1)'(MAX_PACKET_BITS - BYTE_MARGIN);
    localparam logic [CNT_W:0] LIM_RESTART = (CNT_W + 1)'(MAX_PACKET_BITS - RESTART_MARGIN);
    localparam logic [CNT_W:0] ADDR_COST   = (CNT_W + 1)'(ADDRESS_CODES);

    t_seq_state       r_state;
    t_seq_state       n_state;
    t_item_pos        r_pos;
    t_item_pos        n_pos;
    logic             r_fast;
    logic             r_reading;
    logic             n_reading;
    logic             r_err;
    logic             n_err;
    logic [CNT_W-1:0] r_bits;
    logic [CNT_W-1:0] n_bits;
    logic [7:0]       r_addr;
    logic [7:0]       n_addr;
    logic [7:0]       r_data;
    logic [7:0]       n_data;
    logic             r_last;
    logic             n_last;
    logic             r_drop;
    logic             n_drop;

    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_need_rs;
    logic [CNT_W:0]   w_sum;
    logic             w_rs_fail;
    logic             w_byte_fail;
    logic             w_fail;
    logic [7:0]       w_item_byte;
    t_shift_ctl       w_shift_ctl;
    t_shift_sts       w_shift_sts;

    assign w_in_acc  = i_item.valid && i_item.ready;
    assign w_out_acc = o_code.valid && o_code.ready;

    // budget check for a later item: restart first, then the data byte after it
    assign w_need_rs   = (i_item.action != r_reading);
    assign w_sum       = {1'b0, r_bits} + (w_need_rs ? ADDR_COST : '0);
    assign w_rs_fail   = w_need_rs && ({1'b0, r_bits} > LIM_RESTART);
    assign w_byte_fail = (w_sum > LIM_BYTE);
    assign w_fail      = w_rs_fail || (!w_need_rs && w_byte_fail);
    assign w_item_byte = i_item.action ? READ_BYTE : i_item.byte_value;

    i2cbe_byte_shifter u_shifter (
        .i_clk (i_clk),
        .i_ctl (w_shift_ctl),
        .o_sts (w_shift_sts)
    );

    // fast clock register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast <= 1'b0;
        end else if (i_cfg_we) begin
            r_fast <= i_cfg_wdata;
        end
    end

    // sequencer and command state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= POS_ADDR;
            r_reading <= 1'b0;
            r_err     <= 1'b0;
            r_bits    <= '0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_reading <= n_reading;
            r_err     <= n_err;
            r_bits    <= n_bits;
        end
    end

    // item payload held for the sequencer
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_data <= n_data;
        r_last <= n_last;
        r_drop <= n_drop;
    end

    // next state, shifter control and code outputs
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_reading   = r_reading;
        n_err       = r_err;
        n_bits      = r_bits;
        n_addr      = r_addr;
        n_data      = r_data;
        n_last      = r_last;
        n_drop      = r_drop;
        w_shift_ctl = '{load: 1'b0, shift: 1'b0, value: w_item_byte};

        i_item.ready          = (r_state == S_IDLE);
        o_code.valid          = (r_state != S_IDLE);
        o_code.bit_code       = CODE_ZERO;
        o_code.speed_flag     = 1'b0;
        o_code.end_of_command = 1'b0;
        o_code.aborted        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (r_err) begin
                        if (i_item.last_item) begin
                            n_state = S_ABORT;
                        end
                    end else begin
                        case (r_pos)
                            POS_ADDR: begin
                                n_addr = i_item.byte_value;
                                if (i_item.action || i_item.last_item) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_pos = POS_FIRST;
                                end
                                if (i_item.last_item) begin
                                    n_state = S_ABORT;
                                end
                            end
                            POS_FIRST: begin
                                n_reading = i_item.action;
                                n_pos     = POS_MORE;
                                n_data    = w_item_byte;
                                n_last    = i_item.last_item;
                                n_drop    = 1'b0;
                                n_state   = S_START;
                            end
                            default: begin
                                if (w_fail) begin
                                    n_err = 1'b1;
                                    if (i_item.last_item) begin
                                        n_state = S_ABORT;
                                    end
                                end else begin
                                    n_reading = i_item.action;
                                    n_data    = w_item_byte;
                                    n_last    = i_item.last_item;
                                    if (w_need_rs) begin
                                        // data byte dropped after the restart if over budget
                                        n_drop  = w_byte_fail;
                                        n_state = S_START;
                                    end else begin
                                        n_state          = S_DATA;
                                        w_shift_ctl.load = 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            S_START: begin
                o_code.bit_code   = CODE_START;
                o_code.speed_flag = r_fast && (r_bits == '0);
                w_shift_ctl.value = {r_addr[6:0], r_reading};
                if (w_out_acc) begin
                    n_bits           = r_bits + 1'b1;
                    w_shift_ctl.load = 1'b1;
                    n_state          = S_ADDR;
                end
            end
            S_ADDR: begin
                o_code.bit_code   = {1'b0, w_shift_sts.code_bit};
                w_shift_ctl.value = r_data;
                if (w_out_acc) begin
                    n_bits = r_bits + 1'b1;
                    if (w_shift_sts.done) begin
                        if (r_drop) begin
                            n_err   = 1'b1;
                            n_state = r_last ? S_ABORT : S_IDLE;
                        end else begin
                            w_shift_ctl.load = 1'b1;
                            n_state          = S_DATA;
                        end
                    end else begin
                        w_shift_ctl.shift = 1'b1;
                    end
                end
            end
            S_DATA: begin
                o_code.bit_code = {1'b0, w_shift_sts.code_bit};
                if (w_out_acc) begin
                    n_bits = r_bits + 1'b1;
                    if (w_shift_sts.done) begin
                        n_state = r_last ? S_STOP : S_IDLE;
                    end else begin
                        w_shift_ctl.shift = 1'b1;
                    end
                end
            end
            S_STOP, S_ABORT: begin
                o_code.bit_code       = (r_state == S_STOP) ? CODE_STOP : CODE_ZERO;
                o_code.end_of_command = 1'b1;
                o_code.aborted        = (r_state == S_ABORT);
                // end of command: back to expecting an address
                if (w_out_acc) begin
                    n_state   = S_IDLE;
                    n_pos     = POS_ADDR;
                    n_reading = 1'b0;
                    n_err     = 1'b0;
                    n_bits    = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/i2cbe_checker.sv -----
// port level checks of the i2c transaction bit encoder, bound to the top level
`include "i2c_transaction_bit_encoder_assert.svh"

module i2cbe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_bit_code,
    input logic       i_speed_flag,
    input logic       i_end_of_command,
    input logic       i_aborted
);
    import i2cbe_pkg::*;

    logic w_out_acc;
    logic w_in_acc;

    assign w_out_acc = i_out_valid && i_out_ready;
    assign w_in_acc  = i_in_valid && i_in_ready;

    // no new request is taken while codes are still pending
    `I2CBE_ASSERT_SAME(a_busy_not_ready, i_clk, i_rst_n, i_out_valid, !i_in_ready, "ready while busy")

    // the end of a command returns the block to taking requests
    `I2CBE_ASSERT_NEXT(a_end_to_idle, i_clk, i_rst_n, w_out_acc && i_end_of_command, i_in_ready && !i_out_valid, "not idle after end of command")

    // an idle cycle that takes no request produces no code next
    `I2CBE_ASSERT_NEXT(a_no_spurious_code, i_clk, i_rst_n, !i_out_valid && !w_in_acc, !i_out_valid, "code without a request")

    // speed flag only rides on a start code
    `I2CBE_ASSERT_SAME(a_speed_on_start, i_clk, i_rst_n, i_out_valid && i_speed_flag, i_bit_code == CODE_START, "speed flag off start")

    // an abort is a zero code that ends the command
    `I2CBE_ASSERT_SAME(a_abort_ends, i_clk, i_rst_n, i_out_valid && i_aborted, i_end_of_command && (i_bit_code == CODE_ZERO), "abort not ending command")

endmodule

bind i2c_transaction_bit_encoder i2cbe_checker u_i2cbe_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_item.valid),
    .i_in_ready       (i_item.ready),
    .i_out_valid      (o_code.valid),
    .i_out_ready      (o_code.ready),
    .i_bit_code       (o_code.bit_code),
    .i_speed_flag     (o_code.speed_flag),
    .i_end_of_command (o_code.end_of_command),
    .i_aborted        (o_code.aborted)
);
